[rtl/fcce_pkg.sv]
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types, codes and the helper function of the cluster chain extent walker.
// ----------------------------------------------------------------------------
package fcce_pkg;

    // Input commands.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_RESUME = 2'd2;

    // Table formats; the unused fourth code behaves as FAT32.
    localparam logic [1:0] FAT_12 = 2'd0;
    localparam logic [1:0] FAT_16 = 2'd1;
    localparam logic [1:0] FAT_32 = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_FAT_TYPE     = 3'd0;
    localparam logic [2:0] REG_SECTOR_BYTES = 3'd1;
    localparam logic [2:0] REG_CLUSTER_SECS = 3'd2;
    localparam logic [2:0] REG_DATA_START   = 3'd3;
    localparam logic [2:0] REG_CLUSTER_CNT  = 3'd4;
    localparam logic [2:0] REG_FAT_BYTES    = 3'd5;
    localparam logic [2:0] REG_VOLUME_BASE  = 3'd6;

    // Table entry constants.
    localparam logic [31:0] EOC_FILL_12 = 32'h0000_0FFF;
    localparam logic [31:0] EOC_FILL_16 = 32'h0000_FFFF;
    localparam logic [31:0] EOC_FILL_32 = 32'h0FFF_FFFF;
    localparam logic [31:0] EOC_MIN_12  = 32'h0000_0FF8;
    localparam logic [31:0] EOC_MIN_16  = 32'h0000_FFF8;
    localparam logic [31:0] EOC_MIN_32  = 32'h0FFF_FFF8;
    localparam logic [31:0] MASK_12     = 32'h0000_0FFF;
    localparam logic [31:0] MASK_28     = 32'h0FFF_FFFF;

    // Width of the walk tag kept per cluster in the visited memory.
    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic [1:0]  fat_type;
        logic [15:0] sector_bytes;
        logic [7:0]  cluster_sectors;
        logic [31:0] data_start_sector;
        logic [27:0] cluster_count;
        logic [16:0] fat_bytes;
        logic [63:0] volume_base;
    } t_cfg;

    typedef struct packed {
        logic [63:0] offset;
        logic [63:0] length;
        logic        valid;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_VIS, S_SEC, S_DEV, S_OFF, S_MERGE,
        S_MARK, S_TRD, S_TCAP, S_NEXT, S_FIN, S_FLUSH
    } t_state;

    // End-of-chain test for a table value under the given format.
    function automatic logic chain_end(input logic [1:0] ft, input logic [31:0] v);
        logic r;
        if (ft == FAT_12) begin
            r = (v >= EOC_MIN_12);
        end else if (ft == FAT_16) begin
            r = (v >= EOC_MIN_16);
        end else begin
            r = (v >= EOC_MIN_32);
        end
        return r;
    endfunction

endpackage

[rtl/fcce_in_if.sv]
// ----------------------------------------------------------------------------
// fcce_in_if
// Command channel of the extent walker.
// ----------------------------------------------------------------------------
interface fcce_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] table_address;
    logic [7:0]  table_byte;
    logic [27:0] start_cluster;
    logic [31:0] file_size;
    logic        whole_chain;

    modport source (output valid, command, table_address, table_byte, start_cluster,
                    file_size, whole_chain, input ready);
    modport sink (input valid, command, table_address, table_byte, start_cluster,
                  file_size, whole_chain, output ready);
endinterface

[rtl/fcce_out_if.sv]
// ----------------------------------------------------------------------------
// fcce_out_if
// Extent result channel of the extent walker.
// ----------------------------------------------------------------------------
interface fcce_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] extent_offset;
    logic [63:0] extent_length;
    logic        extent_valid;
    logic        last;
    logic        paused;

    modport source (output valid, extent_offset, extent_length, extent_valid, last, paused,
                    input ready);
    modport sink (input valid, extent_offset, extent_length, extent_valid, last, paused,
                  output ready);
endinterface

[rtl/fcce_cfg_if.sv]
// ----------------------------------------------------------------------------
// fcce_cfg_if
// Register write channel of the extent walker.
// ----------------------------------------------------------------------------
interface fcce_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/fcce_ram.sv]
// ----------------------------------------------------------------------------
// fcce_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/fcce_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fcce_cfg_regs
// Configuration register file; always ready, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module fcce_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fcce_cfg_if.sink      i_cfg,
    output fcce_pkg::t_cfg o_cfg
);
    import fcce_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register decode.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FAT_TYPE:     n_cfg.fat_type          = i_cfg.data[1:0];
                REG_SECTOR_BYTES: n_cfg.sector_bytes      = i_cfg.data[15:0];
                REG_CLUSTER_SECS: n_cfg.cluster_sectors   = i_cfg.data[7:0];
                REG_DATA_START:   n_cfg.data_start_sector = i_cfg.data[31:0];
                REG_CLUSTER_CNT:  n_cfg.cluster_count     = i_cfg.data[27:0];
                REG_FAT_BYTES:    n_cfg.fat_bytes         = i_cfg.data[16:0];
                REG_VOLUME_BASE:  n_cfg.volume_base       = i_cfg.data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fat_type          <= FAT_16;
            r_cfg.sector_bytes      <= 16'd512;
            r_cfg.cluster_sectors   <= 8'd1;
            r_cfg.data_start_sector <= '0;
            r_cfg.cluster_count     <= '0;
            r_cfg.fat_bytes         <= '0;
            r_cfg.volume_base       <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end
endmodule

[rtl/fat_cluster_chain_extents_unit.sv]
// ----------------------------------------------------------------------------
// fat_cluster_chain_extents_unit
// Follows a FAT12/16/32 cluster chain held in a byte RAM and emits merged
// device byte extents, pausing after a fixed number of extents per command.
// ----------------------------------------------------------------------------
//  Channel  Direction  Moves
//  i_in     sink       commands: table byte write, walk start, walk resume
//  o_out    source     extents with last and paused flags
//  i_cfg    sink       register writes (index, data), always ready
//
//  A table byte write leaves the unit idle and ready. A walk reads each table
//  entry byte by byte (2 bytes for FAT12/16, 4 for FAT32) over the single read
//  port of the table RAM and forms the offset with two registered multiplies.
//  After reset, at the 256th walk start and every 255th after it, a clearing
//  pass zeroes the visited-tag RAM; no command is taken meanwhile.
//  A full output register stalls the walk only when a new extent must leave.
// ----------------------------------------------------------------------------
module fat_cluster_chain_extents_unit #(
    parameter int TABLE_BYTES      = 65536,
    parameter int EXTENTS_PER_ITEM = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcce_in_if.sink   i_in,
    fcce_out_if.source o_out,
    fcce_cfg_if.sink  i_cfg
);
    import fcce_pkg::*;

    localparam int AW = $clog2(TABLE_BYTES);
    localparam int NW = $clog2(EXTENTS_PER_ITEM + 1);

    t_cfg cfg;

    fcce_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Control registers.
    t_state             r_state, n_state;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [AW-1:0]      r_clr_idx, n_clr_idx;
    logic               r_clr_walk, n_clr_walk;
    logic [27:0]        r_cur, n_cur;
    logic [63:0]        r_left, n_left;
    logic               r_whole, n_whole;
    logic               r_ppres, n_ppres;
    logic               r_active, n_active;
    logic [NW-1:0]      r_cnt, n_cnt;
    logic               r_hold, n_hold;
    logic               r_stg_v, n_stg_v;
    logic               r_out_v, n_out_v;
    logic [2:0]         r_bidx, n_bidx;

    // Payload registers.
    logic [63:0]        r_poff, n_poff;
    logic [63:0]        r_plen, n_plen;
    t_result            r_stg, n_stg;
    t_result            r_out, n_out;
    logic               r_out_last, n_out_last;
    logic               r_out_pause, n_out_pause;
    logic [35:0]        r_prod, n_prod;
    logic [23:0]        r_cbytes, n_cbytes;
    logic [36:0]        r_sec, n_sec;
    logic [63:0]        r_take, n_take;
    logic [52:0]        r_devrel, n_devrel;
    logic [63:0]        r_off, n_off;
    logic [29:0]        r_eoff, n_eoff;
    logic [2:0]         r_nb, n_nb;
    logic [31:0]        r_ent, n_ent;
    logic               r_ebad, n_ebad;

    // Memory ports.
    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr, tbl_raddr;
    logic [7:0]         tbl_rdata;
    logic               vis_we;
    logic [AW-1:0]      vis_waddr, vis_raddr;
    logic [EPOCH_W-1:0] vis_wdata, vis_rdata;

    fcce_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_in.table_byte),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    fcce_ram #(.WIDTH(EPOCH_W), .DEPTH(TABLE_BYTES)) u_visited (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rdata)
    );

    // Helper terms.
    logic        out_free;
    logic        can_stage;
    logic        tracked;
    logic [31:0] wr_addr;
    logic [31:0] rd_addr;
    logic [31:0] loaded;
    logic [31:0] ent_off;
    logic        ent_bad;
    logic [15:0] pair;
    logic [31:0] ent_val;

    assign out_free  = !r_out_v || o_out.ready;
    assign can_stage = !r_stg_v || out_free;
    assign tracked   = (32'(r_cur) < 32'(TABLE_BYTES));
    assign wr_addr   = 32'(i_in.table_address);
    assign rd_addr   = 32'(r_eoff) + 32'(r_bidx);
    assign loaded    = (32'(cfg.fat_bytes) < 32'(TABLE_BYTES)) ? 32'(cfg.fat_bytes)
                                                                : 32'(TABLE_BYTES);
    assign pair      = r_ent[15:0];

    // Table entry location and bounds check.
    always_comb begin
        if (cfg.fat_type == FAT_12) begin
            ent_off = 32'(r_cur) + 32'(r_cur[27:1]);
            ent_bad = (ent_off + 32'd1 >= loaded);
        end else if (cfg.fat_type == FAT_16) begin
            ent_off = {3'b0, r_cur, 1'b0};
            ent_bad = (ent_off + 32'd2 > loaded);
        end else begin
            ent_off = {2'b0, r_cur, 2'b0};
            ent_bad = (ent_off + 32'd4 > loaded);
        end
    end

    // Next-cluster value decoded from the gathered entry bytes.
    always_comb begin
        if (cfg.fat_type == FAT_12) begin
            if (r_ebad) begin
                ent_val = EOC_FILL_12;
            end else if (r_cur[0]) begin
                ent_val = 32'(pair[15:4]);
            end else begin
                ent_val = 32'(pair) & MASK_12;
            end
        end else if (cfg.fat_type == FAT_16) begin
            ent_val = r_ebad ? EOC_FILL_16 : 32'(pair);
        end else begin
            ent_val = r_ebad ? EOC_FILL_32 : (r_ent & MASK_28);
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.extent_offset = r_out.offset;
    assign o_out.extent_length = r_out.length;
    assign o_out.extent_valid  = r_out.valid;
    assign o_out.last          = r_out_last;
    assign o_out.paused        = r_out_pause;
    assign i_in.ready          = (r_state == S_IDLE);

    // Walk sequencer: next state and datapath.
    always_comb begin
        n_state     = r_state;
        n_epoch     = r_epoch;
        n_clr_idx   = r_clr_idx;
        n_clr_walk  = r_clr_walk;
        n_cur       = r_cur;
        n_left      = r_left;
        n_whole     = r_whole;
        n_ppres     = r_ppres;
        n_active    = r_active;
        n_cnt       = r_cnt;
        n_hold      = r_hold;
        n_stg_v     = r_stg_v;
        n_stg       = r_stg;
        n_out_v     = r_out_v && !o_out.ready;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_pause = r_out_pause;
        n_bidx      = r_bidx;
        n_poff      = r_poff;
        n_plen      = r_plen;
        n_prod      = r_prod;
        n_cbytes    = r_cbytes;
        n_sec       = r_sec;
        n_take      = r_take;
        n_devrel    = r_devrel;
        n_off       = r_off;
        n_eoff      = r_eoff;
        n_nb        = r_nb;
        n_ent       = r_ent;
        n_ebad      = r_ebad;
        tbl_we      = 1'b0;
        tbl_waddr   = wr_addr[AW-1:0];
        tbl_raddr   = rd_addr[AW-1:0];
        vis_we      = 1'b0;
        vis_waddr   = r_clr_idx;
        vis_wdata   = '0;
        vis_raddr   = 32'(r_cur) >= 0 ? AW'(r_cur) : '0;

        unique case (r_state)
            // Sweep the visited tags to zero.
            S_CLEAR: begin
                vis_we    = 1'b1;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == {AW{1'b1}}) begin
                    n_clr_idx = '0;
                    if (r_clr_walk) begin
                        n_epoch    = EPOCH_W'(1);
                        n_clr_walk = 1'b0;
                        n_state    = S_CHECK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            // Take a command item.
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cnt  = '0;
                    n_hold = 1'b0;
                    unique case (i_in.command)
                        CMD_WRITE: begin
                            tbl_we = (wr_addr < 32'(TABLE_BYTES));
                        end
                        CMD_START: begin
                            n_whole  = i_in.whole_chain;
                            n_cur    = i_in.start_cluster;
                            n_left   = (i_in.whole_chain || i_in.file_size == 32'd0)
                                       ? {64{1'b1}} : 64'(i_in.file_size);
                            n_poff   = '0;
                            n_plen   = '0;
                            n_ppres  = 1'b0;
                            n_active = 1'b1;
                            if (r_epoch == {EPOCH_W{1'b1}}) begin
                                n_clr_walk = 1'b1;
                                n_state    = S_CLEAR;
                            end else begin
                                n_epoch = r_epoch + EPOCH_W'(1);
                                n_state = S_CHECK;
                            end
                        end
                        CMD_RESUME: begin
                            if (r_active) begin
                                n_state = S_CHECK;
                            end else begin
                                n_stg   = '0;
                                n_stg_v = 1'b1;
                                n_state = S_FLUSH;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            // Stop tests on the current cluster; visited tag read issued here.
            S_CHECK: begin
                vis_raddr = AW'(r_cur);
                if (r_cur < 28'd2 || 29'(r_cur) >= 29'(cfg.cluster_count) + 29'd2 ||
                    chain_end(cfg.fat_type, 32'(r_cur)) || r_left == 64'd0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_VIS;
                end
            end

            // Revisit test; start the sector multiply.
            S_VIS: begin
                if (tracked && vis_rdata == r_epoch) begin
                    n_cur   = '0;
                    n_state = S_FIN;
                end else begin
                    n_prod   = 36'((r_cur - 28'd2) * cfg.cluster_sectors);
                    n_cbytes = 24'(cfg.cluster_sectors * cfg.sector_bytes);
                    n_state  = S_SEC;
                end
            end

            S_SEC: begin
                n_sec = 37'(cfg.data_start_sector) + 37'(r_prod);
                if (r_whole || r_left >= 64'(r_cbytes)) begin
                    n_take = 64'(r_cbytes);
                end else begin
                    n_take = r_left;
                end
                n_state = S_DEV;
            end

            S_DEV: begin
                n_devrel = 53'(r_sec * cfg.sector_bytes);
                n_state  = S_OFF;
            end

            S_OFF: begin
                n_off   = cfg.volume_base + 64'(r_devrel);
                n_state = S_MERGE;
            end

            // Merge into the pending extent, retire it, or pause when the item is full.
            S_MERGE: begin
                if (r_ppres && r_poff + r_plen == r_off) begin
                    n_plen  = r_plen + r_take;
                    n_state = S_MARK;
                end else if (r_ppres && r_cnt == NW'(EXTENTS_PER_ITEM)) begin
                    n_hold  = 1'b1;
                    n_state = S_FLUSH;
                end else if (!r_ppres || can_stage) begin
                    if (r_ppres) begin
                        if (r_stg_v) begin
                            n_out_v     = 1'b1;
                            n_out       = r_stg;
                            n_out_last  = 1'b0;
                            n_out_pause = 1'b0;
                        end
                        n_stg   = '{offset: r_poff, length: r_plen, valid: 1'b1};
                        n_stg_v = 1'b1;
                        n_cnt   = r_cnt + NW'(1);
                    end
                    n_poff  = r_off;
                    n_plen  = r_take;
                    n_ppres = 1'b1;
                    n_state = S_MARK;
                end
            end

            // Mark visited, charge the budget, locate the table entry.
            S_MARK: begin
                vis_we    = tracked;
                vis_waddr = AW'(r_cur);
                vis_wdata = r_epoch;
                if (!r_whole) begin
                    n_left = r_left - r_take;
                end
                n_eoff = ent_off[29:0];
                n_ebad = ent_bad;
                n_ent  = '0;
                n_bidx = '0;
                n_nb   = (cfg.fat_type == FAT_12 || cfg.fat_type == FAT_16) ? 3'd2 : 3'd4;
                n_state = ent_bad ? S_NEXT : S_TRD;
            end

            S_TRD: begin
                n_state = S_TCAP;
            end

            S_TCAP: begin
                n_ent  = r_ent | (32'(tbl_rdata) << {r_bidx[1:0], 3'b000});
                n_bidx = r_bidx + 3'd1;
                n_state = (r_bidx + 3'd1 == r_nb) ? S_NEXT : S_TRD;
            end

            S_NEXT: begin
                n_cur   = chain_end(cfg.fat_type, ent_val) ? 28'd0 : ent_val[27:0];
                n_state = S_CHECK;
            end

            // Walk stopped: retire the pending extent, pause when the item is full, or report an empty walk.
            S_FIN: begin
                if (r_ppres) begin
                    if (r_cnt == NW'(EXTENTS_PER_ITEM)) begin
                        n_hold  = 1'b1;
                        n_state = S_FLUSH;
                    end else if (can_stage) begin
                        if (r_stg_v) begin
                            n_out_v     = 1'b1;
                            n_out       = r_stg;
                            n_out_last  = 1'b0;
                            n_out_pause = 1'b0;
                        end
                        n_stg    = '{offset: r_poff, length: r_plen, valid: 1'b1};
                        n_stg_v  = 1'b1;
                        n_ppres  = 1'b0;
                        n_active = 1'b0;
                        n_state  = S_FLUSH;
                    end
                end else begin
                    n_active = 1'b0;
                    if (r_cnt == '0) begin
                        n_stg   = '0;
                        n_stg_v = 1'b1;
                    end
                    n_state = S_FLUSH;
                end
            end

            // Send the final extent of this item.
            S_FLUSH: begin
                if (out_free) begin
                    n_out_v     = 1'b1;
                    n_out       = r_stg;
                    n_out_last  = 1'b1;
                    n_out_pause = r_hold;
                    n_stg_v     = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_epoch    <= '0;
            r_clr_idx  <= '0;
            r_clr_walk <= 1'b0;
            r_cur      <= '0;
            r_left     <= '0;
            r_whole    <= 1'b0;
            r_ppres    <= 1'b0;
            r_active   <= 1'b0;
            r_cnt      <= '0;
            r_hold     <= 1'b0;
            r_stg_v    <= 1'b0;
            r_out_v    <= 1'b0;
            r_bidx     <= '0;
        end else begin
            r_state    <= n_state;
            r_epoch    <= n_epoch;
            r_clr_idx  <= n_clr_idx;
            r_clr_walk <= n_clr_walk;
            r_cur      <= n_cur;
            r_left     <= n_left;
            r_whole    <= n_whole;
            r_ppres    <= n_ppres;
            r_active   <= n_active;
            r_cnt      <= n_cnt;
            r_hold     <= n_hold;
            r_stg_v    <= n_stg_v;
            r_out_v    <= n_out_v;
            r_bidx     <= n_bidx;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_poff      <= n_poff;
        r_plen      <= n_plen;
        r_stg       <= n_stg;
        r_out       <= n_out;
        r_out_last  <= n_out_last;
        r_out_pause <= n_out_pause;
        r_prod      <= n_prod;
        r_cbytes    <= n_cbytes;
        r_sec       <= n_sec;
        r_take      <= n_take;
        r_devrel    <= n_devrel;
        r_off       <= n_off;
        r_eoff      <= n_eoff;
        r_nb        <= n_nb;
        r_ent       <= n_ent;
        r_ebad      <= n_ebad;
    end
endmodule
